>>> hdl/mod2x_pkg.sv
package mod2x_pkg;

	typedef enum logic {
		CMD_WRITE  = 1'b0,
		CMD_SCREEN = 1'b1
	} cmd_t;

	localparam int unsigned TableDepth = 256;

	typedef struct packed {
		logic       active;
		logic [1:0] line;
		logic [1:0] col;
	} dot_ctl_t;

	typedef struct packed {
		logic [3:0] upper;
		logic [3:0] lower;
	} dot_nib_t;

	function automatic logic [3:0] cell_rank(input logic [1:0] line, input logic [1:0] col);
		logic [3:0] r;
		case ({line, col})
			4'h0: r = 4'd0;
			4'h1: r = 4'd12;
			4'h2: r = 4'd3;
			4'h3: r = 4'd15;
			4'h4: r = 4'd8;
			4'h5: r = 4'd4;
			4'h6: r = 4'd11;
			4'h7: r = 4'd7;
			4'h8: r = 4'd2;
			4'h9: r = 4'd14;
			4'hA: r = 4'd1;
			4'hB: r = 4'd13;
			4'hC: r = 4'd10;
			4'hD: r = 4'd6;
			4'hE: r = 4'd9;
			4'hF: r = 4'd5;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	// upper nibble in [7:4], lower nibble in [3:0]
	function automatic logic [7:0] level_nibbles(input logic [3:0] lvl, input logic odd_line);
		logic [15:0] row;
		case (lvl)
			4'd0:  row = 16'h0000;
			4'd1:  row = 16'h4010;
			4'd2:  row = 16'h8020;
			4'd3:  row = 16'hC030;
			4'd4:  row = 16'hC134;
			4'd5:  row = 16'hC238;
			4'd6:  row = 16'hC33C;
			4'd7:  row = 16'hC73D;
			4'd8:  row = 16'hCB3E;
			4'd9:  row = 16'hCF3F;
			4'd10: row = 16'hDF7F;
			4'd11: row = 16'hEFBF;
			4'd12: row = 16'hFFFF;
			default: row = 16'h0000;
		endcase
		return odd_line ? row[7:0] : row[15:8];
	endfunction

endpackage

>>> hdl/mod2x_dot.sv
module mod2x_dot
	import mod2x_pkg::*;
(
	input  logic [7:0] tone,
	input  dot_ctl_t   ctl,
	output dot_nib_t   nib
);

	logic [15:0] half_scaled;
	logic [15:0] quot_sum;
	logic [7:0]  step;
	logic [7:0]  step_m1;
	logic [3:0]  lvl;

	// step = floor((384*tone + 255) / 510) = floor((192*tone + 127) / 255)
	assign half_scaled = {1'b0, tone, 7'b0} + {2'b0, tone, 6'b0} + 16'd127;
	assign quot_sum    = half_scaled + 16'd1 + {8'b0, half_scaled[15:8]};
	assign step        = quot_sum[15:8];
	assign step_m1     = step - 8'd1;

	always_comb begin
		if (step == 8'd0) begin
			lvl = 4'd0;
		end else if (cell_rank(ctl.line, ctl.col) <= step_m1[3:0]) begin
			lvl = step_m1[7:4] + 4'd1;
		end else begin
			lvl = step_m1[7:4];
		end
	end

	assign nib = ctl.active ? dot_nib_t'(level_nibbles(lvl, ctl.line[0])) : dot_nib_t'(8'h00);

endmodule

>>> hdl/multilevel_ordered_dither_2x.sv
// A screen item's tones are read from the tone table into stage 1, then screened into the output register.
// Throughput: one item per cycle while item_stall is low; the tone table has one write and two read ports.
// A table write item produces no result.
// Reset (arst_n low, asynchronous) empties the pipeline; the tone table keeps
// no reset value and must be loaded before it is used.
module multilevel_ordered_dither_2x
	import mod2x_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic       command,
	input  logic [7:0] table_index,
	input  logic [7:0] table_value,
	input  logic [7:0] pixel_left,
	input  logic [7:0] pixel_right,
	input  logic       right_valid,
	input  logic [1:0] line_phase,
	input  logic       pair_phase,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] upper_byte,
	output logic [7:0] lower_byte
);

	logic [7:0] tone_mem [TableDepth];

	logic       valid_s1;
	logic [7:0] tone_l_s1;
	logic [7:0] tone_r_s1;
	dot_ctl_t   ctl_l_s1;
	dot_ctl_t   ctl_r_s1;

	logic       out_valid_q;
	logic [7:0] upper_q;
	logic [7:0] lower_q;

	logic       out_free;
	logic       s1_adv;
	logic       in_take;
	dot_nib_t   nib_l;
	dot_nib_t   nib_r;

	assign out_free   = !out_valid_q || !result_stall;
	assign s1_adv     = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign in_take    = item_valid && !item_stall;

	always_ff @(posedge clk) begin
		if (in_take && command == CMD_WRITE) begin
			tone_mem[table_index] <= table_value;
		end
		if (in_take && command == CMD_SCREEN) begin
			tone_l_s1 <= tone_mem[pixel_left];
			tone_r_s1 <= tone_mem[pixel_right];
			ctl_l_s1  <= '{active: pixel_left != 8'd0, line: line_phase,
				col: {pair_phase, 1'b0}};
			ctl_r_s1  <= '{active: right_valid && pixel_right != 8'd0, line: line_phase,
				col: {pair_phase, 1'b1}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= (command == CMD_SCREEN);
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	mod2x_dot u_dot_l (
		.tone (tone_l_s1),
		.ctl  (ctl_l_s1),
		.nib  (nib_l)
	);

	mod2x_dot u_dot_r (
		.tone (tone_r_s1),
		.ctl  (ctl_r_s1),
		.nib  (nib_r)
	);

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			upper_q <= {nib_l.upper, nib_r.upper};
			lower_q <= {nib_l.lower, nib_r.lower};
		end
	end

	assign result_valid = out_valid_q;
	assign upper_byte   = upper_q;
	assign lower_byte   = lower_q;

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && command == CMD_WRITE) |=> !valid_s1)
		else $error("table write entered the screening stage");

	a_screen_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && command == CMD_SCREEN) |=> valid_s1)
		else $error("screen transfer lost");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && out_valid_q && result_stall))
		else $error("input stalled without a blocked pipeline");

	a_zero_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && !ctl_l_s1.active && !ctl_r_s1.active)
		|=> (upper_byte == 8'h00 && lower_byte == 8'h00))
		else $error("empty pixel pair gave nonzero dots");

	a_stage_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && !in_take) |=> (!valid_s1 && result_valid))
		else $error("stage advance lost its item");

endmodule

>>> test/multilevel_ordered_dither_2x_tb.sv
`timescale 1ns / 100ps

module multilevel_ordered_dither_2x_tb;
	import mod2x_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned MAX_REPORTS = 10;

	// fill rank of each cell, indexed by {line, column}
	localparam logic [3:0] FILL_RANK [16] = '{
		4'd0, 4'd12, 4'd3, 4'd15,
		4'd8, 4'd4, 4'd11, 4'd7,
		4'd2, 4'd14, 4'd1, 4'd13,
		4'd10, 4'd6, 4'd9, 4'd5
	};

	// nibbles per level: even line first/second, odd line first/second
	localparam logic [15:0] DOT_ROWS [13] = '{
		16'h0000, 16'h4010, 16'h8020, 16'hC030, 16'hC134, 16'hC238, 16'hC33C,
		16'hC73D, 16'hCB3E, 16'hCF3F, 16'hDF7F, 16'hEFBF, 16'hFFFF
	};

	typedef struct packed {
		logic [7:0] upper;
		logic [7:0] lower;
	} dot_pair_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_stall;
	logic       command = CMD_WRITE;
	logic [7:0] table_index = '0;
	logic [7:0] table_value = '0;
	logic [7:0] pixel_left = '0;
	logic [7:0] pixel_right = '0;
	logic       right_valid = 1'b0;
	logic [1:0] line_phase = '0;
	logic       pair_phase = 1'b0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic [7:0] upper_byte;
	logic [7:0] lower_byte;

	logic [7:0]  tone_map [TableDepth];
	dot_pair_t   expected_dots [$];
	int unsigned fault_count = 0;
	int unsigned cycle_count = 0;
	int unsigned hold_req = 0;
	bit          idle_mode = 1'b0;

	multilevel_ordered_dither_2x u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.command      (command),
		.table_index  (table_index),
		.table_value  (table_value),
		.pixel_left   (pixel_left),
		.pixel_right  (pixel_right),
		.right_valid  (right_valid),
		.line_phase   (line_phase),
		.pair_phase   (pair_phase),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.upper_byte   (upper_byte),
		.lower_byte   (lower_byte)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic note_fault(input string msg);
		fault_count++;
		if (fault_count <= MAX_REPORTS)
			$display("[%0d] %s", cycle_count, msg);
	endtask

	function automatic logic [3:0] dot_level(input logic [7:0] tone, input logic [1:0] line,
			input logic [1:0] col);
		int unsigned k;
		int unsigned lvl;
		k = (384 * tone + 255) / 510;
		if (k == 0)
			return 4'd0;
		lvl = (k - 1) >> 4;
		if (FILL_RANK[{line, col}] <= ((k - 1) & 15))
			lvl++;
		if (lvl > 12)
			lvl = 12;
		return lvl[3:0];
	endfunction

	function automatic dot_pair_t pixel_dots(input logic [7:0] pixel, input logic [1:0] line,
			input logic [1:0] col);
		dot_pair_t  d;
		logic [15:0] row;
		d = '0;
		if (pixel == 8'd0)
			return d;
		row = DOT_ROWS[dot_level(tone_map[pixel], line, col)];
		if (line[0]) begin
			d.upper = {4'h0, row[7:4]};
			d.lower = {4'h0, row[3:0]};
		end else begin
			d.upper = {4'h0, row[15:12]};
			d.lower = {4'h0, row[11:8]};
		end
		if (!col[0]) begin
			d.upper = d.upper << 4;
			d.lower = d.lower << 4;
		end
		return d;
	endfunction

	function automatic dot_pair_t screen_pair(input logic [7:0] pl, input logic [7:0] pr,
			input logic rv, input logic [1:0] lp, input logic pp);
		dot_pair_t l;
		dot_pair_t r;
		l = pixel_dots(pl, lp, {pp, 1'b0});
		r = rv ? pixel_dots(pr, lp, {pp, 1'b1}) : '0;
		return l | r;
	endfunction

	task automatic send_item(input cmd_t cmd, input logic [7:0] idx, input logic [7:0] val,
			input logic [7:0] pl, input logic [7:0] pr, input logic rv,
			input logic [1:0] lp, input logic pp);
		int unsigned r;
		int unsigned gap;
		gap = 0;
		if (idle_mode) begin
			r = $urandom_range(99);
			if (r >= 95)
				gap = $urandom_range(25, 8);
			else if (r >= 75)
				gap = $urandom_range(3, 1);
		end
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid  <= 1'b1;
		command     <= cmd;
		table_index <= idx;
		table_value <= val;
		pixel_left  <= pl;
		pixel_right <= pr;
		right_valid <= rv;
		line_phase  <= lp;
		pair_phase  <= pp;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		if (cmd == CMD_WRITE) begin
			tone_map[idx] = val;
		end else begin
			expected_dots.push_back(screen_pair(pl, pr, rv, lp, pp));
		end
	endtask

	task automatic send_write(input logic [7:0] idx, input logic [7:0] val);
		send_item(CMD_WRITE, idx, val, 8'($urandom), 8'($urandom), 1'($urandom),
			2'($urandom), 1'($urandom));
	endtask

	task automatic send_screen(input logic [7:0] pl, input logic [7:0] pr, input logic rv,
			input logic [1:0] lp, input logic pp);
		send_item(CMD_SCREEN, 8'($urandom), 8'($urandom), pl, pr, rv, lp, pp);
	endtask

	function automatic logic [7:0] random_pixel();
		if ($urandom_range(9) == 0)
			return 8'd0;
		return 8'($urandom_range(255, 1));
	endfunction

	always @(posedge clk) begin
		dot_pair_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_dots.size() == 0) begin
				note_fault($sformatf("unexpected result upper=%02h lower=%02h",
					upper_byte, lower_byte));
			end else begin
				want = expected_dots.pop_front();
				if (upper_byte !== want.upper || lower_byte !== want.lower)
					note_fault($sformatf(
						"mismatch: expected upper=%02h lower=%02h, got upper=%02h lower=%02h",
						want.upper, want.lower, upper_byte, lower_byte));
			end
		end
	end

	initial begin : receiver
		int unsigned stall_left;
		int unsigned r;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				stall_left = hold_req;
				hold_req = 0;
			end
			if (stall_left != 0) begin
				result_stall <= 1'b1;
				stall_left--;
			end else if (!idle_mode) begin
				result_stall <= 1'b0;
			end else begin
				r = $urandom_range(99);
				if (r < 70) begin
					result_stall <= 1'b0;
				end else begin
					result_stall <= 1'b1;
					stall_left = (r < 95) ? $urandom_range(2, 0) : $urandom_range(29, 9);
				end
			end
		end
	end

	task automatic test_directed();
		idle_mode = 1'b0;
		send_write(8'hFF, 8'hFF);
		send_write(8'h01, 8'h00);
		send_write(8'hAA, 8'h01);
		send_write(8'h55, 8'h2A);
		send_screen(8'hFF, 8'hFF, 1'b1, 2'd0, 1'b0);
		send_screen(8'hFF, 8'hFF, 1'b1, 2'd3, 1'b1);
		send_screen(8'h00, 8'h00, 1'b1, 2'd1, 1'b0);
		send_screen(8'h01, 8'hAA, 1'b1, 2'd2, 1'b1);
		send_screen(8'hAA, 8'h00, 1'b1, 2'd0, 1'b0);
		send_screen(8'hAA, 8'hAA, 1'b1, 2'd1, 1'b1);
		send_screen(8'h55, 8'hFF, 1'b0, 2'd1, 1'b0);
		send_screen(8'h00, 8'hFF, 1'b1, 2'd2, 1'b0);
		send_screen(8'h55, 8'h55, 1'b1, 2'd3, 1'b0);
		// overwrite an entry and use it on the very next transfer
		send_write(8'h80, 8'hC0);
		send_screen(8'h80, 8'h80, 1'b1, 2'd2, 1'b1);
		send_write(8'h80, 8'h7F);
		send_screen(8'h80, 8'hFF, 1'b1, 2'd1, 1'b1);
		send_write(8'hFF, 8'h00);
		send_screen(8'hFF, 8'h80, 1'b1, 2'd0, 1'b1);
	endtask

	task automatic test_table_load();
		idle_mode = 1'b1;
		for (int i = 0; i < TableDepth; i++)
			send_write(8'(i), 8'($urandom));
	endtask

	task automatic test_random_screen();
		for (int i = 0; i < 300; i++) begin
			if (i % 150 == 0)
				idle_mode = (i % 300 == 0);
			if ($urandom_range(9) == 0)
				send_write(8'($urandom), 8'($urandom));
			else
				send_screen(random_pixel(), random_pixel(), $urandom_range(99) < 85,
					2'($urandom), 1'($urandom));
		end
	endtask

	task automatic test_output_backpressure();
		idle_mode = 1'b0;
		hold_req = 80;
		for (int i = 0; i < 40; i++)
			send_screen(random_pixel(), random_pixel(), 1'b1, 2'($urandom), 1'($urandom));
		idle_mode = 1'b1;
	endtask

	task automatic drain();
		int unsigned waited;
		item_valid <= 1'b0;
		waited = 0;
		while (expected_dots.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (expected_dots.size() != 0)
			note_fault($sformatf("%0d results never arrived", expected_dots.size()));
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_table_load();
		test_random_screen();
		test_output_backpressure();
		test_random_screen();
		drain();
		if (fault_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
